@@ rtl/qrr_pkg.sv @@
`timescale 1ns / 1ps
package qrr_pkg;

  localparam int CoefBits  = 16;
  localparam int FracBits  = 16;
  localparam int OutBits   = 34;

  localparam int MagW      = CoefBits;
  localparam int ProdW     = 2 * CoefBits;
  localparam int DiscW     = 2 * CoefBits + 1;
  localparam int DiscPairs = (DiscW + 1) / 2;
  localparam int RootW     = DiscPairs + FracBits;
  localparam int RemW      = RootW + 2;
  localparam int BsW       = MagW + FracBits;
  localparam int NumW      = ((RootW > BsW) ? RootW : BsW) + 1;
  localparam int DenW      = CoefBits + 1;
  localparam int QW        = ((NumW > OutBits) ? NumW : OutBits) + 1;

  typedef enum logic [1:0] {
    ST_NOT_QUAD = 2'd0,
    ST_TWO      = 2'd1,
    ST_DOUBLE   = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef struct packed {
    status_e                status;
    logic                   a_neg;
    logic                   b_pos;
    logic [MagW-1:0]        b_mag;
    logic [MagW-1:0]        a_mag;
    logic [2*DiscPairs-1:0] disc;
    logic [RootW-1:0]       root;
    logic [RemW-1:0]        rem;
  } sqrt_stage_t;

  typedef struct packed {
    status_e         status;
    logic            a_neg;
    logic [DenW-1:0] den;
    logic [NumW-1:0] num_p;
    logic [NumW-1:0] num_m;
    logic            neg_p;
    logic            neg_m;
    logic [NumW-1:0] quo_p;
    logic [NumW-1:0] quo_m;
    logic [DenW-1:0] rem_p;
    logic [DenW-1:0] rem_m;
  } div_stage_t;

endpackage

@@ rtl/quadratic_real_roots.sv @@
`timescale 1ns / 1ps
// Throughput: one coefficient set per cycle; busy is always low and every stage is a register.
// The depth comes from the square root (one root bit per stage) and the two dividers
// (one quotient bit per stage). Reset is asynchronous, active low, and clears the valid bits only.
// The receiver cannot stall, so every result leaves the pipeline without waiting.
module quadratic_real_roots import qrr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [CoefBits-1:0] coef_quad_i,
  input  logic signed [CoefBits-1:0] coef_lin_i,
  input  logic signed [CoefBits-1:0] coef_const_i,
  output logic                       valid_o,
  output logic [1:0]                 status_o,
  output logic signed [OutBits-1:0]  root_plus_o,
  output logic signed [OutBits-1:0]  root_minus_o
);

  // The pipeline never stalls, so a new transfer is possible in every cycle.
  assign busy = 1'b0;

  // Stage 1: input register.
  logic                       v1_q;
  logic signed [CoefBits-1:0] a_q, b_q, c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= coef_quad_i;
    b_q <= coef_lin_i;
    c_q <= coef_const_i;
  end

  // Stage 2: magnitudes and the two products b*b and |a|*|c|.
  logic [MagW-1:0]  a_mag, b_mag, c_mag;
  logic             v2_q;
  logic [ProdW-1:0] b2_q, p_q;
  logic             a_neg2_q, c_neg2_q, b_pos2_q, a_zero2_q;
  logic [MagW-1:0]  a_mag2_q, b_mag2_q;

  assign a_mag = a_q[CoefBits-1] ? MagW'(-a_q) : MagW'(a_q);
  assign b_mag = b_q[CoefBits-1] ? MagW'(-b_q) : MagW'(b_q);
  assign c_mag = c_q[CoefBits-1] ? MagW'(-c_q) : MagW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_q      <= b_mag * b_mag;
    p_q       <= a_mag * c_mag;
    a_neg2_q  <= a_q[CoefBits-1];
    c_neg2_q  <= c_q[CoefBits-1];
    b_pos2_q  <= !b_q[CoefBits-1] && (b_q != '0);
    a_zero2_q <= (a_q == '0);
    a_mag2_q  <= a_mag;
    b_mag2_q  <= b_mag;
  end

  // Stage 3: exact discriminant and the status that follows from a zero leading term or its sign.
  logic [ProdW+1:0] b2_x, p4_x, d_x;
  logic             neg4ac;
  status_e          status3;

  assign b2_x   = (ProdW+2)'(b2_q);
  assign p4_x   = {p_q, 2'b00};
  assign neg4ac = (a_neg2_q != c_neg2_q) && (p_q != '0);
  assign d_x    = neg4ac ? (b2_x + p4_x) : (b2_x - p4_x);

  always_comb begin
    priority if (a_zero2_q) begin
      status3 = ST_NOT_QUAD;
    end else if (neg4ac || (b2_x > p4_x)) begin
      status3 = ST_TWO;
    end else if (b2_x == p4_x) begin
      status3 = ST_DOUBLE;
    end else begin
      status3 = ST_NONE;
    end
  end

  // Square root, one root bit per stage: sq_q[0] is the entry, sq_q[RootW] the result.
  logic        sv_q [RootW+1];
  sqrt_stage_t sq_q [RootW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0].status <= status3;
    sq_q[0].a_neg  <= a_neg2_q;
    sq_q[0].b_pos  <= b_pos2_q;
    sq_q[0].b_mag  <= b_mag2_q;
    sq_q[0].a_mag  <= a_mag2_q;
    sq_q[0].disc   <= (2*DiscPairs)'(d_x[DiscW-1:0]);
    sq_q[0].root   <= '0;
    sq_q[0].rem    <= '0;
  end

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    localparam int K = RootW - 1 - g;
    logic [1:0]       pair;
    logic [RemW-1:0]  rem_sh, trial;
    sqrt_stage_t      nxt;

    if (K >= FracBits) begin : g_data
      assign pair = sq_q[g].disc[2*(K-FracBits)+1 : 2*(K-FracBits)];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {sq_q[g].rem[RemW-3:0], pair};
    assign trial  = {sq_q[g].root, 2'b01};

    always_comb begin
      nxt = sq_q[g];
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {sq_q[g].root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {sq_q[g].root[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[g+1] <= 1'b0;
      end else begin
        sv_q[g+1] <= sv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[g+1] <= nxt;
    end
  end

  // Numerators -b*2^F +/- s as sign and magnitude.
  logic [NumW-1:0] s_x, bs_x;
  sqrt_stage_t     sq_end;

  assign sq_end = sq_q[RootW];
  assign s_x    = NumW'(sq_end.root);
  assign bs_x   = NumW'({sq_end.b_mag, {FracBits{1'b0}}});

  logic       dv_q [NumW+1];
  div_stage_t dq_q [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= sv_q[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q[0].status <= sq_end.status;
    dq_q[0].a_neg  <= sq_end.a_neg;
    dq_q[0].den    <= {sq_end.a_mag, 1'b0};
    dq_q[0].quo_p  <= '0;
    dq_q[0].quo_m  <= '0;
    dq_q[0].rem_p  <= '0;
    dq_q[0].rem_m  <= '0;
    if (sq_end.b_pos) begin
      dq_q[0].neg_p <= (s_x < bs_x);
      dq_q[0].num_p <= (s_x >= bs_x) ? (s_x - bs_x) : (bs_x - s_x);
      dq_q[0].neg_m <= 1'b1;
      dq_q[0].num_m <= bs_x + s_x;
    end else begin
      dq_q[0].neg_p <= 1'b0;
      dq_q[0].num_p <= bs_x + s_x;
      dq_q[0].neg_m <= (bs_x < s_x);
      dq_q[0].num_m <= (bs_x >= s_x) ? (bs_x - s_x) : (s_x - bs_x);
    end
  end

  // Two restoring dividers by 2|a|, one quotient bit per stage.
  for (genvar j = 0; j < NumW; j++) begin : g_div
    localparam int Bit = NumW - 1 - j;
    logic [DenW:0] rp_sh, rm_sh, den_x;
    div_stage_t    nxt;

    assign den_x = {1'b0, dq_q[j].den};
    assign rp_sh = {dq_q[j].rem_p, dq_q[j].num_p[Bit]};
    assign rm_sh = {dq_q[j].rem_m, dq_q[j].num_m[Bit]};

    always_comb begin
      nxt = dq_q[j];
      if (rp_sh >= den_x) begin
        nxt.rem_p = DenW'(rp_sh - den_x);
        nxt.quo_p = {dq_q[j].quo_p[NumW-2:0], 1'b1};
      end else begin
        nxt.rem_p = DenW'(rp_sh);
        nxt.quo_p = {dq_q[j].quo_p[NumW-2:0], 1'b0};
      end
      if (rm_sh >= den_x) begin
        nxt.rem_m = DenW'(rm_sh - den_x);
        nxt.quo_m = {dq_q[j].quo_m[NumW-2:0], 1'b1};
      end else begin
        nxt.rem_m = DenW'(rm_sh);
        nxt.quo_m = {dq_q[j].quo_m[NumW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dq_q[j+1] <= nxt;
    end
  end

  // Output stage: sign the quotient, saturate to the output range, and zero the roots
  // when there are none or the leading term is zero.
  localparam logic [QW-1:0] LimPos = QW'((65'd1 << (OutBits - 1)) - 65'd1);
  localparam logic [QW-1:0] LimNeg = QW'(65'd1 << (OutBits - 1));

  function automatic logic [OutBits-1:0] finish_root(input logic [NumW-1:0] q,
                                                     input logic            neg_in);
    logic [QW-1:0] qx;
    logic [QW-1:0] v;
    logic          neg;
    qx  = QW'(q);
    neg = neg_in && (q != '0);
    if (neg) begin
      v = (qx > LimNeg) ? -LimNeg : -qx;
    end else begin
      v = (qx > LimPos) ? LimPos : qx;
    end
    return v[OutBits-1:0];
  endfunction

  div_stage_t         dq_end;
  logic               has_roots;
  logic [OutBits-1:0] rp_d, rm_d;
  logic               valid_q;
  logic [1:0]         status_q;
  logic [OutBits-1:0] rp_q, rm_q;

  assign dq_end    = dq_q[NumW];
  assign has_roots = (dq_end.status == ST_TWO) || (dq_end.status == ST_DOUBLE);
  assign rp_d = has_roots ? finish_root(dq_end.quo_p, dq_end.neg_p != dq_end.a_neg) : '0;
  assign rm_d = has_roots ? finish_root(dq_end.quo_m, dq_end.neg_m != dq_end.a_neg) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= dq_end.status;
    rp_q     <= rp_d;
    rm_q     <= rm_d;
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign root_plus_o  = rp_q;
  assign root_minus_o = rm_q;

endmodule

@@ test/quadratic_real_roots_checker.sv @@
`timescale 1ns / 1ps
module quadratic_real_roots_checker import qrr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic signed [CoefBits-1:0] coef_quad_i,
  input  logic signed [CoefBits-1:0] coef_lin_i,
  input  logic signed [CoefBits-1:0] coef_const_i,
  input  logic                       valid_i,
  input  logic [1:0]                 status_i,
  input  logic [OutBits-1:0]         root_plus_i,
  input  logic [OutBits-1:0]         root_minus_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    status_e            status;
    logic [OutBits-1:0] root_plus;
    logic [OutBits-1:0] root_minus;
  } roots_t;

  roots_t roots_q[$];

  // Signed quotient of a numerator by 2a, truncated toward zero, saturated to OutBits.
  function automatic logic [OutBits-1:0] divide_by_2a(logic num_neg, logic [127:0] num_mag,
                                                      longint a);
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] lim_pos;
    logic [127:0] lim_neg;
    logic         neg;
    den = (a < 0) ? 128'(-a) << 1 : 128'(a) << 1;
    q = num_mag / den;
    neg = (num_neg != (a < 0)) && (q != 0);
    lim_pos = (128'd1 << (OutBits - 1)) - 1;
    lim_neg = 128'd1 << (OutBits - 1);
    if (neg) begin
      if (q > lim_neg) q = lim_neg;
      q = -q;
    end else if (q > lim_pos) begin
      q = lim_pos;
    end
    return q[OutBits-1:0];
  endfunction

  // Floor of the square root of d * 2^(2*FracBits), one result bit at a time.
  function automatic logic [127:0] scaled_isqrt(logic [127:0] d);
    logic [127:0] x;
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    x = d << (2 * FracBits);
    root = 0;
    rem = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((x >> (2 * k)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_quadratic(longint a, longint b, longint c);
    roots_t       r;
    logic signed [127:0] d;
    logic [127:0] bs;
    logic [127:0] s;
    r = '0;
    r.status = ST_NOT_QUAD;
    if (a == 0) return r;
    d = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    bs = (b < 0) ? 128'(-b) << FracBits : 128'(b) << FracBits;
    if (d < 0) begin
      r.status = ST_NONE;
    end else if (d == 0) begin
      r.status = ST_DOUBLE;
      r.root_plus = divide_by_2a(b > 0, bs, a);
      r.root_minus = r.root_plus;
    end else begin
      r.status = ST_TWO;
      s = scaled_isqrt(d);
      if (b > 0) begin
        r.root_plus = (s >= bs) ? divide_by_2a(1'b0, s - bs, a) : divide_by_2a(1'b1, bs - s, a);
        r.root_minus = divide_by_2a(1'b1, bs + s, a);
      end else begin
        r.root_plus = divide_by_2a(1'b0, bs + s, a);
        r.root_minus = (bs >= s) ? divide_by_2a(1'b0, bs - s, a) : divide_by_2a(1'b1, s - bs, a);
      end
    end
    return r;
  endfunction

  assign pending_o = roots_q.size();

  initial errors_o = 0;

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && start_i && !busy_i) begin
      roots_q.push_back(solve_quadratic(coef_quad_i, coef_lin_i, coef_const_i));
    end
    if (rst_ni && valid_i) begin
      if (roots_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d plus %0d minus %0d",
                 $time, status_i, root_plus_i, root_minus_i);
        errors_o++;
      end else begin
        want = roots_q.pop_front();
        if (status_i !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
          errors_o++;
        end
        if (root_plus_i !== want.root_plus) begin
          $display("%0t: root_plus expected %0h actual %0h", $time, want.root_plus,
                   root_plus_i);
          errors_o++;
        end
        if (root_minus_i !== want.root_minus) begin
          $display("%0t: root_minus expected %0h actual %0h", $time, want.root_minus,
                   root_minus_i);
          errors_o++;
        end
      end
    end
  end

endmodule

@@ test/quadratic_real_roots_tb.sv @@
`timescale 1ns / 1ps
// Top of the bench. It drives coefficient sets on the command port and gives the verdict;
// the checker beside the block predicts every result and compares it.
module quadratic_real_roots_tb import qrr_pkg::*;;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic signed [CoefBits-1:0] coef_quad;
  logic signed [CoefBits-1:0] coef_lin;
  logic signed [CoefBits-1:0] coef_const;
  logic                       valid;
  logic [1:0]                 status;
  logic signed [OutBits-1:0]  root_plus;
  logic signed [OutBits-1:0]  root_minus;
  int                         errors;
  int                         pending;

  // A 12 ns clock, high and low for half a period each.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  quadratic_real_roots u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .coef_quad_i  (coef_quad),
    .coef_lin_i   (coef_lin),
    .coef_const_i (coef_const),
    .valid_o      (valid),
    .status_o     (status),
    .root_plus_o  (root_plus),
    .root_minus_o (root_minus)
  );

  quadratic_real_roots_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .coef_quad_i  (coef_quad),
    .coef_lin_i   (coef_lin),
    .coef_const_i (coef_const),
    .valid_i      (valid),
    .status_i     (status),
    .root_plus_i  (root_plus),
    .root_minus_i (root_minus),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Offers one coefficient set at the falling edge and holds it until a transfer happens.
  // Start is left high afterwards so that back-to-back sets keep it high without a glitch.
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    coef_quad <= a;
    coef_lin <= b;
    coef_const <= c;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // A random coefficient picked to hit small, extreme or fully random values.
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 20)) - 10);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Builds a set from chosen integer roots so that double roots and real pairs turn up often.
  task automatic send_from_roots();
    int r1;
    int r2;
    int k;
    r1 = $urandom_range(0, 120) - 60;
    r2 = ($urandom_range(0, 2) == 0) ? r1 : $urandom_range(0, 120) - 60;
    k = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
    send_coefs(16'(k), 16'(-k * (r1 + r2)), 16'(k * r1 * r2));
  endtask

  initial begin
    int burst;
    rst_ni = 1'b0;
    start = 1'b0;
    coef_quad = '0;
    coef_lin = '0;
    coef_const = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets: a zero leading term, each sign of the discriminant,
    // double roots of both signs and the extremes of every coefficient.
    send_coefs(16'd0, 16'd5, 16'd3);
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd1, 16'd0, 16'd0);
    send_coefs(16'd1, -16'sd3, 16'd2);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, -16'sd2, 16'd1);
    send_coefs(-16'sd4, 16'd4, -16'sd1);
    send_coefs(16'd1, 16'd1, 16'd1);
    send_coefs(16'd2, 16'd0, -16'sd1);
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'd1, 16'h8000, 16'h7fff);
    send_coefs(16'h8000, 16'd0, 16'h7fff);
    send_coefs(16'd1, 16'h7fff, 16'h8000);
    send_coefs(-16'sd1, 16'h8000, 16'd0);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h5555, 16'haaaa, 16'h5555);

    // Let the pipeline drain completely once before the random part.
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    // Random bursts with gaps; four in ten sets are built from roots, the rest are free.
    for (int n = 0; n < 1650; n += burst) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 9) < 4) send_from_roots();
        else send_coefs(pick_coef(), pick_coef(), pick_coef());
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
